>>> src/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
`default_nettype none

package qau_pkg;

  localparam int DW        = 16;
  localparam int FRAC_BITS = 12;

  // sum of four squares of DW-bit values, rounded up to an even width
  localparam int SQ_W     = 2 * DW + 2;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int LEN_W    = SQ_STEPS;
  localparam int SQ_REM_W = LEN_W + 2;

  // quotient of a normalize never exceeds 2^FRAC_BITS
  localparam int QW       = FRAC_BITS + 1;
  localparam int NUM_W    = DW + FRAC_BITS + 1;
  localparam int DIV_REM_W = LEN_W + 1;

  localparam int SUM_W = 2 * DW + 2;

  // latency terms: squares and their sum, isqrt root bits, rounded numerator, divide, merge
  localparam int LAT = 2 + SQ_STEPS + 1 + QW + 1;

  typedef enum logic [1:0] {
    MODE_PROD = 2'd0,
    MODE_VEC  = 2'd1,
    MODE_CONJ = 2'd2,
    MODE_NORM = 2'd3
  } mode_t;

  typedef logic signed [DW-1:0] word_t;
  typedef word_t [3:0] quad_t;

  typedef struct packed {
    mode_t mode;
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t a_w;
    word_t b_x;
    word_t b_y;
    word_t b_z;
    word_t b_w;
  } in_t;

  typedef struct packed {
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_w;
    logic  overflow;
    logic  zero_length;
  } out_t;

endpackage

`default_nettype wire

>>> src/qau_prod_lane.sv
// One product lane: four signed products, signed sum, rounding and saturation.
`default_nettype none

module qau_prod_lane (
  input  wire logic          clk,
  input  wire qau_pkg::quad_t a,
  input  wire qau_pkg::quad_t b,
  input  wire logic [3:0]    neg,
  output qau_pkg::word_t     r,
  output logic               ovf
);

  localparam logic signed [qau_pkg::SUM_W-1:0] HALF =
    qau_pkg::SUM_W'(1) <<< (qau_pkg::FRAC_BITS - 1);
  localparam logic signed [qau_pkg::SUM_W-1:0] MAXV =
    qau_pkg::SUM_W'((1 << (qau_pkg::DW - 1)) - 1);
  localparam logic signed [qau_pkg::SUM_W-1:0] MINV = -MAXV - 1;

  logic signed [2*qau_pkg::DW-1:0] p_r [4];
  logic [3:0]                      neg_r;
  logic signed [qau_pkg::SUM_W-1:0] sum;
  logic signed [qau_pkg::SUM_W-1:0] scaled;
  qau_pkg::word_t                  r_nxt;
  logic                            ovf_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      p_r[i] <= $signed(a[i]) * $signed(b[i]);
    end
    neg_r <= neg;
    r     <= r_nxt;
    ovf   <= ovf_nxt;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (neg_r[i]) begin
        sum = sum - qau_pkg::SUM_W'(p_r[i]);
      end else begin
        sum = sum + qau_pkg::SUM_W'(p_r[i]);
      end
    end
    // round to nearest, ties toward plus infinity
    scaled = (sum + HALF) >>> qau_pkg::FRAC_BITS;
    if (scaled > MAXV) begin
      r_nxt   = qau_pkg::DW'(MAXV);
      ovf_nxt = 1'b1;
    end else if (scaled < MINV) begin
      r_nxt   = qau_pkg::DW'(MINV);
      ovf_nxt = 1'b1;
    end else begin
      r_nxt   = qau_pkg::DW'(scaled);
      ovf_nxt = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/qau_isqrt.sv
// Pipelined length unit: sum of squares, then one root bit per stage.
`default_nettype none

module qau_isqrt (
  input  wire logic             clk,
  input  wire qau_pkg::quad_t   a,
  output logic [qau_pkg::LEN_W-1:0] len
);

  localparam int N  = qau_pkg::SQ_STEPS;
  localparam int RW = qau_pkg::SQ_REM_W;
  localparam int TW = qau_pkg::LEN_W;
  localparam int SW = qau_pkg::SQ_W;
  localparam int PW = 2 * qau_pkg::DW;

  logic [2*qau_pkg::DW-1:0] sq_r [4];
  logic [SW-1:0]            s_r;
  logic [RW-1:0]            rem_r  [N];
  logic [TW-1:0]            root_r [N];
  logic [SW-1:0]            sh_r   [N];
  logic [RW-1:0]            src_rem  [N];
  logic [TW-1:0]            src_root [N];
  logic [SW-1:0]            src_sh   [N];
  logic [RW-1:0]            rem_nxt  [N];
  logic [TW-1:0]            root_nxt [N];
  logic [RW-1:0]            cur      [N];
  logic [RW-1:0]            trial    [N];

  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_sh[0]   = s_r;
    for (int j = 1; j < N; j++) begin
      src_rem[j]  = rem_r[j-1];
      src_root[j] = root_r[j-1];
      src_sh[j]   = sh_r[j-1];
    end
    for (int j = 0; j < N; j++) begin
      cur[j]   = {src_rem[j][RW-3:0], src_sh[j][SW-1 -: 2]};
      trial[j] = {src_root[j], 2'b01};
      if (cur[j] >= trial[j]) begin
        rem_nxt[j]  = cur[j] - trial[j];
        root_nxt[j] = {src_root[j][TW-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = cur[j];
        root_nxt[j] = {src_root[j][TW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= unsigned'(PW'($signed(a[i])) * PW'($signed(a[i])));
    end
    s_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);
    for (int j = 0; j < N; j++) begin
      rem_r[j]  <= rem_nxt[j];
      root_r[j] <= root_nxt[j];
      sh_r[j]   <= {src_sh[j][SW-3:0], 2'b00};
    end
  end

  assign len = root_r[N-1];

endmodule

`default_nettype wire

>>> src/qau_div_lane.sv
// One normalize lane: rounded numerator, then one quotient bit per stage.
`default_nettype none

module qau_div_lane (
  input  wire logic [qau_pkg::DW-1:0]    mag,
  input  wire logic [qau_pkg::LEN_W-1:0] len,
  input  wire logic                      clk,
  output logic [qau_pkg::QW-1:0]         q
);

  localparam int N  = qau_pkg::QW;
  localparam int NW = qau_pkg::NUM_W;
  localparam int RW = qau_pkg::DIV_REM_W;
  localparam int LW = qau_pkg::LEN_W;

  logic [NW-1:0] num_r;
  logic [LW-1:0] den0_r;
  logic [RW-1:0] rem_r [N];
  logic [N-1:0]  q_r   [N];
  logic [N-1:0]  lo_r  [N];
  logic [LW-1:0] den_r [N];
  logic [RW-1:0] src_rem [N];
  logic [N-1:0]  src_q   [N];
  logic [N-1:0]  src_lo  [N];
  logic [LW-1:0] src_den [N];
  logic [RW-1:0] cur     [N];
  logic [RW-1:0] rem_nxt [N];
  logic [N-1:0]  q_nxt   [N];

  always_comb begin
    // top bits of the numerator are already below the divisor
    src_rem[0] = RW'(num_r[NW-1:N]);
    src_q[0]   = '0;
    src_lo[0]  = num_r[N-1:0];
    src_den[0] = den0_r;
    for (int k = 1; k < N; k++) begin
      src_rem[k] = rem_r[k-1];
      src_q[k]   = q_r[k-1];
      src_lo[k]  = lo_r[k-1];
      src_den[k] = den_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      cur[k] = {src_rem[k][RW-2:0], src_lo[k][N-1]};
      if (cur[k] >= RW'(src_den[k])) begin
        rem_nxt[k] = cur[k] - RW'(src_den[k]);
        q_nxt[k]   = {src_q[k][N-2:0], 1'b1};
      end else begin
        rem_nxt[k] = cur[k];
        q_nxt[k]   = {src_q[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= (NW'(mag) << qau_pkg::FRAC_BITS) + NW'(len >> 1);
    den0_r <= len;
    for (int k = 0; k < N; k++) begin
      rem_r[k] <= rem_nxt[k];
      q_r[k]   <= q_nxt[k];
      lo_r[k]  <= {src_lo[k][N-2:0], 1'b0};
      den_r[k] <= src_den[k];
    end
  end

  assign q = q_r[N-1];

endmodule

`default_nettype wire

>>> src/quaternion_arithmetic_unit.sv
// Top level: operand routing, lanes, length unit, delay line and result merge.
`default_nettype none

// Fully pipelined: one operation is taken every cycle and busy never rises.
// Every mode has the same latency from the start transfer to the out_valid
// strobe, so results leave in start order. The latency is set by the
// normalize path: a register each for the squares and their sum, 17 root-bit
// stages of the square root, a register for the rounded numerator, 13
// quotient-bit stages of the four divide lanes and one output register. Results are shown
// for one cycle only; the receiver must take them as they come.
module quaternion_arithmetic_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire qau_pkg::in_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output qau_pkg::out_t       out_data
);

  localparam int LAT = qau_pkg::LAT;
  localparam int DW  = qau_pkg::DW;
  localparam qau_pkg::word_t WMAX = qau_pkg::word_t'((1 << (DW - 1)) - 1);
  localparam qau_pkg::word_t WMIN = ~WMAX;

  typedef struct packed {
    qau_pkg::mode_t                 mode;
    qau_pkg::quad_t                 conj;
    logic                           conj_ovf;
    logic [3:0]                     neg;
    logic [3:0][DW-1:0]             mag;
    logic                           zl;
    qau_pkg::quad_t                 prod;
    logic                           prod_ovf;
  } meta_t;

  logic                      accept;
  qau_pkg::quad_t            qa;
  qau_pkg::word_t            bw;
  qau_pkg::quad_t            la [4];
  qau_pkg::quad_t            lb [4];
  logic [3:0]                lneg [4];
  qau_pkg::quad_t            prod;
  logic [3:0]                prod_ovf;
  logic [qau_pkg::LEN_W-1:0] len;
  logic [qau_pkg::QW-1:0]    quo [4];
  meta_t                     m_in;
  meta_t                     m_join;
  meta_t                     meta_r [LAT-1];
  logic [LAT-2:0]            vld_r;
  meta_t                     m_out;
  qau_pkg::quad_t            res;
  logic                      ovf;
  logic                      zl;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign qa = {in_data.a_w, in_data.a_z, in_data.a_y, in_data.a_x};
  assign bw = (in_data.mode == qau_pkg::MODE_VEC) ? '0 : in_data.b_w;

  // Hamilton product terms per component; index 0..3 is x, y, z, w
  always_comb begin
    la[0] = {in_data.a_z, in_data.a_y, in_data.a_w, in_data.a_x};
    lb[0] = {in_data.b_y, in_data.b_z, in_data.b_x, bw};
    lneg[0] = 4'b1000;
    la[1] = {in_data.a_x, in_data.a_z, in_data.a_w, in_data.a_y};
    lb[1] = {in_data.b_z, in_data.b_x, in_data.b_y, bw};
    lneg[1] = 4'b1000;
    la[2] = {in_data.a_y, in_data.a_x, in_data.a_w, in_data.a_z};
    lb[2] = {in_data.b_x, in_data.b_y, in_data.b_z, bw};
    lneg[2] = 4'b1000;
    la[3] = {in_data.a_z, in_data.a_y, in_data.a_x, in_data.a_w};
    lb[3] = {in_data.b_z, in_data.b_y, in_data.b_x, bw};
    lneg[3] = 4'b1110;
  end

  for (genvar i = 0; i < 4; i++) begin : g_prod
    qau_prod_lane u_prod (
      .clk (clk),
      .a   (la[i]),
      .b   (lb[i]),
      .neg (lneg[i]),
      .r   (prod[i]),
      .ovf (prod_ovf[i])
    );
  end

  qau_isqrt u_isqrt (
    .clk (clk),
    .a   (qa),
    .len (len)
  );

  for (genvar i = 0; i < 4; i++) begin : g_div
    qau_div_lane u_div (
      .mag (meta_r[qau_pkg::SQ_STEPS+1].mag[i]),
      .len (len),
      .clk (clk),
      .q   (quo[i])
    );
  end

  always_comb begin
    m_in          = '0;
    m_in.mode     = in_data.mode;
    m_in.conj[3]  = in_data.a_w;
    m_in.conj_ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (qa[i] == WMIN) begin
        m_in.conj[i]  = WMAX;
        m_in.conj_ovf = 1'b1;
      end else begin
        m_in.conj[i] = -qa[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      m_in.neg[i] = qa[i][DW-1];
      m_in.mag[i] = qa[i][DW-1] ? DW'(-qa[i]) : DW'(qa[i]);
    end
    m_in.zl = (qa == '0);
  end

  // product results join the payload once the lanes are done
  always_comb begin
    m_join          = meta_r[1];
    m_join.prod     = prod;
    m_join.prod_ovf = |prod_ovf;
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= m_in;
    for (int k = 1; k < LAT - 1; k++) begin
      if (k == 2) begin
        meta_r[k] <= m_join;
      end else begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  assign m_out = meta_r[LAT-2];

  always_comb begin
    res = '0;
    ovf = 1'b0;
    zl  = 1'b0;
    unique case (m_out.mode) inside
      qau_pkg::MODE_PROD, qau_pkg::MODE_VEC: begin
        res = m_out.prod;
        ovf = m_out.prod_ovf;
      end
      qau_pkg::MODE_CONJ: begin
        res = m_out.conj;
        ovf = m_out.conj_ovf;
      end
      qau_pkg::MODE_NORM: begin
        if (m_out.zl) begin
          zl = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            res[i] = m_out.neg[i] ? -DW'(quo[i]) : DW'(quo[i]);
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[LAT-3:0], accept};
      out_valid <= vld_r[LAT-2];
    end
    out_data.r_x         <= res[0];
    out_data.r_y         <= res[1];
    out_data.r_z         <= res[2];
    out_data.r_w         <= res[3];
    out_data.overflow    <= ovf;
    out_data.zero_length <= zl;
  end

endmodule

`default_nettype wire

>>> test/tb_quaternion_arithmetic_unit.sv
// Testbench for the quaternion arithmetic unit: directed and random operations vs. a predictor.
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit;

  logic           clk;
  logic           rst_n;
  logic           start;
  qau_pkg::in_t   in_data;
  logic           busy;
  logic           out_valid;
  qau_pkg::out_t  out_data;

  qau_pkg::out_t  pending_results[$];
  int    error_count;
  int    mode_count[4];
  int    result_count;
  int    sat_count;
  int    zero_len_count;
  bit    allow_gaps;

  quaternion_arithmetic_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic qau_pkg::word_t sat_word(longint v, ref logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return qau_pkg::word_t'(v);
  endfunction

  // round to nearest, ties up: arithmetic shift floors
  function automatic longint round_back(longint s);
    return (s + (longint'(1) << (qau_pkg::FRAC_BITS - 1))) >>> qau_pkg::FRAC_BITS;
  endfunction

  function automatic qau_pkg::out_t quat_predict(qau_pkg::in_t q);
    qau_pkg::out_t r;
    longint  ax, ay, az, aw, bx, by, bz, bw;
    longint  p[4];
    longint  comp[4];
    longint unsigned sq, len, mag, quo;
    longint  v;
    logic    ovf;
    ax = q.a_x; ay = q.a_y; az = q.a_z; aw = q.a_w;
    bx = q.b_x; by = q.b_y; bz = q.b_z; bw = q.b_w;
    ovf = 1'b0;
    r = '0;
    case (q.mode)
      qau_pkg::MODE_PROD, qau_pkg::MODE_VEC: begin
        if (q.mode == qau_pkg::MODE_VEC) bw = 0;
        p[3] = aw * bw - ax * bx - ay * by - az * bz;
        p[0] = ax * bw + aw * bx + ay * bz - az * by;
        p[1] = ay * bw + aw * by + az * bx - ax * bz;
        p[2] = az * bw + aw * bz + ax * by - ay * bx;
        r.r_x = sat_word(round_back(p[0]), ovf);
        r.r_y = sat_word(round_back(p[1]), ovf);
        r.r_z = sat_word(round_back(p[2]), ovf);
        r.r_w = sat_word(round_back(p[3]), ovf);
      end
      qau_pkg::MODE_CONJ: begin
        r.r_x = sat_word(-ax, ovf);
        r.r_y = sat_word(-ay, ovf);
        r.r_z = sat_word(-az, ovf);
        r.r_w = q.a_w;
      end
      default: begin
        sq  = ax * ax + ay * ay + az * az + aw * aw;
        len = int_sqrt(sq);
        if (len == 0) begin
          r.zero_length = 1'b1;
        end else begin
          comp[0] = ax; comp[1] = ay; comp[2] = az; comp[3] = aw;
          for (int i = 0; i < 4; i++) begin
            mag = (comp[i] < 0) ? -comp[i] : comp[i];
            quo = ((mag << qau_pkg::FRAC_BITS) + (len >> 1)) / len;
            v   = longint'(quo);
            if (comp[i] < 0) v = -v;
            p[i] = v;
          end
          r.r_x = sat_word(p[0], ovf);
          r.r_y = sat_word(p[1], ovf);
          r.r_z = sat_word(p[2], ovf);
          r.r_w = sat_word(p[3], ovf);
        end
      end
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // expected result recorded on every start transfer
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_results.push_back(quat_predict(in_data));
      mode_count[in_data.mode]++;
    end
  end

  always @(posedge clk) begin
    qau_pkg::out_t exp_r;
    if (rst_n && out_valid) begin
      result_count++;
      if (out_data.overflow) sat_count++;
      if (out_data.zero_length) zero_len_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.r_x !== exp_r.r_x)
          $display("%0t: r_x expected %0d actual %0d", $time, exp_r.r_x, out_data.r_x);
        if (out_data.r_y !== exp_r.r_y)
          $display("%0t: r_y expected %0d actual %0d", $time, exp_r.r_y, out_data.r_y);
        if (out_data.r_z !== exp_r.r_z)
          $display("%0t: r_z expected %0d actual %0d", $time, exp_r.r_z, out_data.r_z);
        if (out_data.r_w !== exp_r.r_w)
          $display("%0t: r_w expected %0d actual %0d", $time, exp_r.r_w, out_data.r_w);
        if (out_data.overflow !== exp_r.overflow)
          $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow,
                   out_data.overflow);
        if (out_data.zero_length !== exp_r.zero_length)
          $display("%0t: zero_length expected %b actual %b", $time, exp_r.zero_length,
                   out_data.zero_length);
        if (out_data !== exp_r) error_count++;
      end
    end
  end

  // one start transfer; start stays high when the next item follows at once
  task automatic send_op(qau_pkg::in_t item);
    int gap;
    gap = allow_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic qau_pkg::word_t rand_word(bit narrow);
    if (narrow) return qau_pkg::word_t'($urandom_range(0, 16383)) - 16'sd8192;
    return qau_pkg::word_t'($urandom);
  endfunction

  function automatic qau_pkg::in_t make_op(qau_pkg::mode_t m,
                                           qau_pkg::word_t ax, qau_pkg::word_t ay,
                                           qau_pkg::word_t az, qau_pkg::word_t aw,
                                           qau_pkg::word_t bx, qau_pkg::word_t by,
                                           qau_pkg::word_t bz, qau_pkg::word_t bw);
    qau_pkg::in_t t;
    t.mode = m;
    t.a_x = ax; t.a_y = ay; t.a_z = az; t.a_w = aw;
    t.b_x = bx; t.b_y = by; t.b_z = bz; t.b_w = bw;
    return t;
  endfunction

  task automatic test_directed();
    localparam qau_pkg::word_t MAXW = 16'sh7fff;
    localparam qau_pkg::word_t MINW = 16'sh8000;
    localparam qau_pkg::word_t ONE  = 16'sh1000;
    allow_gaps = 1'b1;
    send_op(make_op(qau_pkg::MODE_PROD, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_op(make_op(qau_pkg::MODE_PROD, ONE, 0, 0, 0, 0, ONE, 0, 0));
    send_op(make_op(qau_pkg::MODE_PROD, MAXW, MAXW, MAXW, MAXW,
                    MAXW, MAXW, MAXW, MAXW));
    send_op(make_op(qau_pkg::MODE_PROD, MINW, MINW, MINW, MINW,
                    MINW, MINW, MINW, MINW));
    send_op(make_op(qau_pkg::MODE_PROD, MAXW, MINW, MAXW, MINW,
                    MINW, MAXW, MINW, MAXW));
    // half-LSB ties in rounding
    send_op(make_op(qau_pkg::MODE_PROD, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd2048));
    send_op(make_op(qau_pkg::MODE_PROD, 0, 0, 0, -16'sd1, 0, 0, 0, 16'sd2048));
    send_op(make_op(qau_pkg::MODE_VEC, ONE, 16'sd3, -16'sd7, ONE, ONE, ONE, ONE, MAXW));
    send_op(make_op(qau_pkg::MODE_VEC, MINW, MINW, MINW, MINW,
                    MINW, MINW, MINW, MINW));
    send_op(make_op(qau_pkg::MODE_VEC, MAXW, MAXW, MAXW, MAXW, MINW, MINW, MINW, 0));
    send_op(make_op(qau_pkg::MODE_CONJ, MINW, MINW, MINW, MINW, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_CONJ, MAXW, -16'sd1, 0, MINW,
                    MAXW, MAXW, MAXW, MAXW));
    send_op(make_op(qau_pkg::MODE_NORM, 0, 0, 0, 0, MAXW, MINW, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, 0, 0, 0, 16'sd1, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, 0, 0, 0, MINW, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, MAXW, MAXW, MAXW, MAXW, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, MINW, MINW, MINW, MINW, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, 16'sd3, -16'sd4, 0, 0, 0, 0, 0, 0));
    send_op(make_op(qau_pkg::MODE_NORM, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 0, 0, 0, 0));
    release_start();
  endtask

  task automatic test_random_mix(int count, bit gaps);
    qau_pkg::in_t t;
    bit  narrow;
    allow_gaps = gaps;
    for (int i = 0; i < count; i++) begin
      narrow = ($urandom_range(0, 2) != 0);
      t = make_op(qau_pkg::mode_t'($urandom_range(0, 3)),
                  rand_word(narrow), rand_word(narrow), rand_word(narrow), rand_word(narrow),
                  rand_word(narrow), rand_word(narrow), rand_word(narrow), rand_word(narrow));
      send_op(t);
    end
    release_start();
  endtask

  // tiny operands: small lengths and rounding near zero
  task automatic test_small_normalize(int count);
    qau_pkg::in_t t;
    allow_gaps = 1'b1;
    for (int i = 0; i < count; i++) begin
      t = make_op(qau_pkg::MODE_NORM,
                  qau_pkg::word_t'($urandom_range(0, 6)) - 16'sd3,
                  qau_pkg::word_t'($urandom_range(0, 6)) - 16'sd3,
                  qau_pkg::word_t'($urandom_range(0, 6)) - 16'sd3,
                  qau_pkg::word_t'($urandom_range(0, 6)) - 16'sd3,
                  qau_pkg::word_t'($urandom), qau_pkg::word_t'($urandom),
                  qau_pkg::word_t'($urandom), qau_pkg::word_t'($urandom));
      send_op(t);
    end
    release_start();
  endtask

  initial begin
    int waited;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    error_count = 0;
    result_count = 0;
    sat_count = 0;
    zero_len_count = 0;
    allow_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(700, 1'b1);
    test_random_mix(400, 1'b0);
    test_small_normalize(150);
    test_random_mix(300, 1'b1);

    waited = 0;
    while (pending_results.size() != 0 && waited < 10 * qau_pkg::LAT) begin
      @(posedge clk);
      waited++;
    end
    repeat (qau_pkg::LAT + 5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end

    $display("Covered %0d results: product %0d, vector %0d, conjugate %0d, normalize %0d",
             result_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("Saturated results %0d, zero-length results %0d", sat_count, zero_len_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
